// ----- rtl/core/rbav_pkg.sv -----
// shared types and codes for the ring bump allocator
package rbav_pkg;

   localparam int PtrWidth   = 17;
   localparam int RoundWidth = 18;
   localparam int AddrWidth  = 32;

   typedef logic [PtrWidth-1:0]   ptr_type;
   typedef logic [RoundWidth-1:0] round_type;
   typedef logic [AddrWidth-1:0]  addr_type;

   typedef enum logic [2:0] {
      ACT_ALLOC   = 3'd0,
      ACT_CLEAR   = 3'd1,
      ACT_PREPARE = 3'd2,
      ACT_FINISH  = 3'd3,
      ACT_REVERT  = 3'd4,
      ACT_QUERY   = 3'd5
   } action_type;

   typedef enum logic {
      CSR_HEAP_BASE  = 1'b0,
      CSR_HEAP_BYTES = 1'b1
   } csr_index_type;

   localparam ptr_type HeapBytesReset = 17'h10000;

   // request word after the input register: size already turned into a block count
   typedef struct packed {
      logic [2:0] action;
      round_type  quot;
      addr_type   query_address;
   } req_word_type;

endpackage

// ----- rtl/core/ring_bump_allocator_with_advance_unit.sv -----
// top level of the ring bump allocator with advance mark
//
// Requests arrive on the req_ stream: req_tuser carries the action (alloc, clear,
// prepare advance, finish advance, revert advance, query), req_tdata the alloc
// size and the query address. Each request gives exactly one response word on
// the rsp_ stream with the alloc result, the query answer, the empty flag and
// the advance-pending flag as they stand after that request.
// The csr_ channel writes heap_base (index 0) and heap_bytes (index 1); it is
// always ready and should only be used while no request is in flight.
// A request passes through the input register (which also works out the aligned
// block count), then through the pointer update into the response register.
// Throughput is one request per cycle while rsp_tready does not stall, since the
// pointer update is a single pass of compares and adds on registered pointers.
// A stalled rsp_tready holds the response word; one more request is still
// taken into the input register, after which req_tready drops.
// Reset (synchronous, active high) empties the heap, drops any advance mark and
// sets heap_base to 0 and heap_bytes to 65536.
module ring_bump_allocator_with_advance_unit #(
   parameter int HEAP_CAPACITY = 65536,
   parameter int ALIGN_BYTES   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // alloc_size[16:0], query_address[48:17], zero fill
   input  logic [2:0]  req_tuser,   // action[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // alloc_ok[0], alloc_address[32:1], is_allocated[33],
                                    // heap_empty[34], advance_pending[35], zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   logic                   step_valid;
   logic                   step_ready;
   rbav_pkg::req_word_type step_word;

   rbav_req_stage #(
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .step_ready (step_ready),
      .step_valid (step_valid),
      .step_word  (step_word)
   );

   rbav_alloc_core #(
      .HEAP_CAPACITY (HEAP_CAPACITY),
      .ALIGN_BYTES   (ALIGN_BYTES)
   ) u_alloc_core (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .step_valid (step_valid),
      .step_ready (step_ready),
      .step_word  (step_word),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/core/rbav_req_stage.sv -----
// input register of the allocator, with the aligned block count of the request
module rbav_req_stage #(
   parameter int ALIGN_BYTES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [55:0]          req_tdata,
   input  logic [2:0]           req_tuser,
   input  logic                 step_ready,
   output logic                 step_valid,
   output rbav_pkg::req_word_type step_word
);

   // ceil(size / align) through a reciprocal, exact for every 18-bit numerator
   localparam int     AlignLog   = $clog2(ALIGN_BYTES);
   localparam int     RecipShift = rbav_pkg::RoundWidth + AlignLog;
   localparam longint RecipMul   = ((longint'(1) << RecipShift) + ALIGN_BYTES - 1) / ALIGN_BYTES;
   localparam logic [19:0] RecipConst = 20'(RecipMul);
   localparam logic [17:0] AlignMinusOne = 18'(ALIGN_BYTES - 1);

   logic                  valid_ff;
   logic                  valid_in;
   rbav_pkg::req_word_type word_ff;
   rbav_pkg::req_word_type word_in;
   logic [17:0]           numer;
   logic [37:0]           recip_prod;
   logic                  req_fire;

   assign req_tready = !valid_ff || step_ready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      numer      = 18'(req_tdata[16:0]) + AlignMinusOne;
      recip_prod = {20'b0, numer} * {18'b0, RecipConst};
      word_in.action        = req_tuser;
      word_in.quot          = 18'(recip_prod >> RecipShift);
      word_in.query_address = req_tdata[48:17];
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (step_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_fire) begin
         word_ff <= word_in;
      end
   end

   assign step_valid = valid_ff;
   assign step_word  = word_ff;

endmodule

// ----- rtl/core/rbav_alloc_core.sv -----
// allocator state, per-request update and result register
module rbav_alloc_core #(
   parameter int HEAP_CAPACITY = 65536,
   parameter int ALIGN_BYTES   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [31:0]            csr_data,
   input  logic                   step_valid,
   output logic                   step_ready,
   input  rbav_pkg::req_word_type step_word,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata
);

   localparam logic [24:0] CapLimit   = 25'(HEAP_CAPACITY);
   localparam logic [12:0] AlignConst = 13'(ALIGN_BYTES);

   rbav_pkg::addr_type heap_base_ff;
   rbav_pkg::ptr_type  heap_bytes_ff;

   rbav_pkg::ptr_type upper_ff, upper_in;
   rbav_pkg::ptr_type wrap_ff, wrap_in;
   rbav_pkg::ptr_type origin_ff, origin_in;
   rbav_pkg::ptr_type adv_ptr_ff, adv_ptr_in;
   logic              adv_valid_ff, adv_valid_in;
   logic              can_cycle_ff, can_cycle_in;

   logic               rsp_valid_ff;
   logic               ok_ff, ok_in;
   rbav_pkg::addr_type addr_ff, addr_in;
   logic               hit_ff, hit_in;
   logic               empty_ff, empty_in;
   logic               pend_ff;

   rbav_pkg::ptr_type   heap_end;
   rbav_pkg::ptr_type   upper_room;
   rbav_pkg::ptr_type   wrap_room;
   logic [30:0]         round_full;
   rbav_pkg::round_type size_r;
   logic [32:0]         base_w;
   logic [32:0]         query_w;
   logic                step_fire;

   assign step_ready = !rsp_valid_ff || rsp_tready;
   assign step_fire  = step_valid && step_ready;
   assign csr_ready  = 1'b1;

   always_comb begin
      heap_end   = ({8'b0, heap_bytes_ff} > CapLimit) ? CapLimit[16:0] : heap_bytes_ff;
      upper_room = (heap_end > upper_ff) ? heap_end - upper_ff : '0;
      wrap_room  = (origin_ff > wrap_ff) ? origin_ff - wrap_ff : '0;
      round_full = 31'(step_word.quot) * 31'(AlignConst);
      size_r     = round_full[17:0];
      base_w     = {1'b0, heap_base_ff};
      query_w    = {1'b0, step_word.query_address};

      upper_in     = upper_ff;
      wrap_in      = wrap_ff;
      origin_in    = origin_ff;
      adv_ptr_in   = adv_ptr_ff;
      adv_valid_in = adv_valid_ff;
      can_cycle_in = can_cycle_ff;
      ok_in        = 1'b0;
      addr_in      = '0;
      hit_in       = 1'b0;

      case (step_word.action)
         rbav_pkg::ACT_ALLOC: begin
            if ((!adv_valid_ff || can_cycle_ff || adv_ptr_ff >= origin_ff)
                && {1'b0, upper_room} >= size_r) begin
               ok_in    = 1'b1;
               addr_in  = heap_base_ff + 32'(upper_ff);
               upper_in = upper_ff + size_r[16:0];
            end else if ((!adv_valid_ff || can_cycle_ff || adv_ptr_ff < origin_ff)
                         && {1'b0, wrap_room} >= size_r) begin
               ok_in   = 1'b1;
               addr_in = heap_base_ff + 32'(wrap_ff);
               wrap_in = wrap_ff + size_r[16:0];
            end
         end
         rbav_pkg::ACT_CLEAR: begin
            upper_in     = '0;
            wrap_in      = '0;
            origin_in    = '0;
            adv_ptr_in   = '0;
            adv_valid_in = 1'b0;
            can_cycle_in = 1'b0;
         end
         rbav_pkg::ACT_PREPARE: begin
            can_cycle_in = (wrap_ff == '0);
            if (wrap_ff == '0 || upper_room >= wrap_room) begin
               adv_ptr_in = upper_ff;
            end else begin
               adv_ptr_in = wrap_ff;
            end
            adv_valid_in = 1'b1;
         end
         rbav_pkg::ACT_FINISH: begin
            if (adv_valid_ff) begin
               if (adv_ptr_ff < origin_ff) begin
                  upper_in = wrap_ff;
                  wrap_in  = '0;
               end else if (!can_cycle_ff) begin
                  wrap_in = '0;
               end
               origin_in    = adv_ptr_ff;
               adv_ptr_in   = '0;
               adv_valid_in = 1'b0;
               can_cycle_in = 1'b0;
               // heap drained by the move: restart from the bottom
               if (upper_in == origin_in && wrap_in == '0) begin
                  upper_in  = '0;
                  wrap_in   = '0;
                  origin_in = '0;
               end
            end
         end
         rbav_pkg::ACT_REVERT: begin
            if (adv_valid_ff) begin
               if (origin_ff <= adv_ptr_ff) begin
                  upper_in = adv_ptr_ff;
                  if (can_cycle_ff) begin
                     wrap_in = '0;
                  end
               end else begin
                  wrap_in = adv_ptr_ff;
               end
               adv_ptr_in   = '0;
               adv_valid_in = 1'b0;
            end
         end
         rbav_pkg::ACT_QUERY: begin
            hit_in = (query_w >= base_w && query_w < base_w + 33'(wrap_ff))
                  || (query_w >= base_w + 33'(origin_ff)
                      && query_w < base_w + 33'(upper_ff));
         end
         default: begin
         end
      endcase

      empty_in = (upper_in == origin_in) && (wrap_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= '0;
         heap_bytes_ff <= rbav_pkg::HeapBytesReset;
         upper_ff      <= '0;
         wrap_ff       <= '0;
         origin_ff     <= '0;
         adv_ptr_ff    <= '0;
         adv_valid_ff  <= 1'b0;
         can_cycle_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               rbav_pkg::CSR_HEAP_BASE:  heap_base_ff  <= csr_data;
               rbav_pkg::CSR_HEAP_BYTES: heap_bytes_ff <= csr_data[16:0];
               default: begin
               end
            endcase
         end
         if (step_fire) begin
            upper_ff     <= upper_in;
            wrap_ff      <= wrap_in;
            origin_ff    <= origin_in;
            adv_ptr_ff   <= adv_ptr_in;
            adv_valid_ff <= adv_valid_in;
            can_cycle_ff <= can_cycle_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (step_fire) begin
         ok_ff    <= ok_in;
         addr_ff  <= addr_in;
         hit_ff   <= hit_in;
         empty_ff <= empty_in;
         pend_ff  <= adv_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, pend_ff, empty_ff, hit_ff, addr_ff, ok_ff};

`ifndef SYNTHESIS
   a_upper_in_range: assert property (@(posedge clock) disable iff (reset)
      upper_ff <= rbav_pkg::HeapBytesReset && origin_ff <= rbav_pkg::HeapBytesReset)
      else $error("pointer beyond largest heap");

   a_no_mark_zero: assert property (@(posedge clock) disable iff (reset)
      !adv_valid_ff |-> adv_ptr_ff == '0)
      else $error("advance mark set while no advance pending");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !step_fire |=> $stable({upper_ff, wrap_ff, origin_ff, adv_ptr_ff,
                              adv_valid_ff, can_cycle_ff}))
      else $error("allocator state moved without a request");

   a_fail_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ok_ff |-> addr_ff == '0)
      else $error("failed allocation reports an address");
`endif

endmodule

// ----- bench/tb_ring_bump_allocator_with_advance_unit.sv -----
// self-checking bench for the ring bump allocator with advance mark
`timescale 1ns / 100ps

module tb_ring_bump_allocator_with_advance_unit;

   localparam int AlignBytes = 16;
   localparam int HeapCap    = 65536;

   // codes outside the action set, which the block must ignore
   localparam logic [2:0] ActUnused6 = 3'd6;
   localparam logic [2:0] ActUnused7 = 3'd7;

   typedef struct {
      logic        ok;
      logic [31:0] address;
      logic        hit;
      logic        empty;
      logic        pending;
   } alloc_reply_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;   // alloc_size[16:0], query_address[48:17], zero fill
   logic [2:0]  req_tuser  = '0;   // action[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // alloc_ok[0], alloc_address[32:1], is_allocated[33],
                                   // heap_empty[34], advance_pending[35], zero fill
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [31:0] csr_data   = '0;

   // mirrored allocator state, byte offsets from the heap base
   logic [31:0] upper_off, wrap_off, origin_off, mark_off;
   logic        mark_held, cycle_ok;
   logic [31:0] base_reg, bytes_reg;

   alloc_reply_type reply_queue[$];
   int fail_count     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_cycles    = 0;

   ring_bump_allocator_with_advance_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] upper_room();
      logic [31:0] heap_end;
      heap_end = (bytes_reg > 32'(HeapCap)) ? 32'(HeapCap) : bytes_reg;
      return (heap_end > upper_off) ? heap_end - upper_off : 32'd0;
   endfunction

   function automatic logic [31:0] wrap_room();
      return (origin_off > wrap_off) ? origin_off - wrap_off : 32'd0;
   endfunction

   function automatic logic heap_is_empty();
      return (upper_off == origin_off) && (wrap_off == 32'd0);
   endfunction

   function automatic void wipe_ring();
      upper_off  = '0;
      wrap_off   = '0;
      origin_off = '0;
      mark_off   = '0;
      mark_held  = 1'b0;
      cycle_ok   = 1'b0;
   endfunction

   // applies one request to the mirrored state and returns the word it must produce
   function automatic alloc_reply_type ring_update(logic [2:0] act, logic [16:0] size_in,
                                                   logic [31:0] qaddr);
      alloc_reply_type r;
      logic [31:0]     size;
      logic [33:0]     q;
      logic [33:0]     b;
      r.ok      = 1'b0;
      r.address = '0;
      r.hit     = 1'b0;
      size      = {15'd0, size_in};
      if (size % AlignBytes != 0)
         size = size + 32'(AlignBytes) - size % AlignBytes;
      q = {2'b00, qaddr};
      b = {2'b00, base_reg};
      case (act)
         rbav_pkg::ACT_ALLOC: begin
            if ((!mark_held || cycle_ok || mark_off >= origin_off) && upper_room() >= size) begin
               r.ok      = 1'b1;
               r.address = base_reg + upper_off;
               upper_off = upper_off + size;
            end else if ((!mark_held || cycle_ok || mark_off < origin_off)
                         && wrap_room() >= size) begin
               r.ok      = 1'b1;
               r.address = base_reg + wrap_off;
               wrap_off  = wrap_off + size;
            end
         end
         rbav_pkg::ACT_CLEAR: wipe_ring();
         rbav_pkg::ACT_PREPARE: begin
            cycle_ok = (wrap_off == 32'd0);
            if (cycle_ok || upper_room() >= wrap_room())
               mark_off = upper_off;
            else
               mark_off = wrap_off;
            mark_held = 1'b1;
         end
         rbav_pkg::ACT_FINISH: begin
            if (mark_held) begin
               if (mark_off < origin_off) begin
                  upper_off = wrap_off;
                  wrap_off  = '0;
               end else if (!cycle_ok) begin
                  wrap_off = '0;
               end
               origin_off = mark_off;
               mark_off   = '0;
               mark_held  = 1'b0;
               cycle_ok   = 1'b0;
               if (heap_is_empty())
                  wipe_ring();
            end
         end
         rbav_pkg::ACT_REVERT: begin
            if (mark_held) begin
               if (origin_off <= mark_off) begin
                  upper_off = mark_off;
                  if (cycle_ok)
                     wrap_off = '0;
               end else begin
                  wrap_off = mark_off;
               end
               mark_off  = '0;
               mark_held = 1'b0;
            end
         end
         rbav_pkg::ACT_QUERY: begin
            // no wrap-around on the query side
            r.hit = (q >= b && q < b + 34'(wrap_off))
                 || (q >= b + 34'(origin_off) && q < b + 34'(upper_off));
         end
         default: ;
      endcase
      r.empty   = heap_is_empty();
      r.pending = mark_held;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // response check first, then config and request words taken at this edge
   always @(posedge clock) begin
      alloc_reply_type want;
      if (reset) begin
         wipe_ring();
         base_reg  = '0;
         bytes_reg = 32'd65536;
         reply_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_queue.size() == 0) begin
               $display("%0t: response word expected none actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = reply_queue.pop_front();
               check_field("alloc_ok", 32'(want.ok), 32'(rsp_tdata[0]));
               check_field("alloc_address", want.address, rsp_tdata[32:1]);
               check_field("is_allocated", 32'(want.hit), 32'(rsp_tdata[33]));
               check_field("heap_empty", 32'(want.empty), 32'(rsp_tdata[34]));
               check_field("advance_pending", 32'(want.pending), 32'(rsp_tdata[35]));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == rbav_pkg::CSR_HEAP_BASE)
               base_reg = csr_data;
            else
               bytes_reg = csr_data & 32'h0001_FFFF;
         end
         if (req_tvalid && req_tready)
            reply_queue.push_back(ring_update(req_tuser, req_tdata[16:0], req_tdata[48:17]));
      end
   end

   // receiver side: random stalls, or a long hold-off when asked for
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // leaves tvalid high on return so back-to-back words need no second assignment
   task automatic send_request(logic [2:0] act, logic [16:0] size, logic [31:0] qaddr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'd0, qaddr, size};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (reply_queue.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(rbav_pkg::csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_request(rbav_pkg::ACT_QUERY, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'd1, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'd17, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'h10000, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'h1FFFF, 32'd0);
      send_request(rbav_pkg::ACT_QUERY, 17'd0, 32'd47);
      send_request(rbav_pkg::ACT_QUERY, 17'd0, 32'd48);
      send_request(rbav_pkg::ACT_QUERY, 17'd0, 32'hFFFF_FFFF);
      // finish and revert with no mark held
      send_request(rbav_pkg::ACT_FINISH, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_REVERT, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_PREPARE, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'd32, 32'd0);
      send_request(rbav_pkg::ACT_FINISH, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'd65456, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'd16, 32'd0);
      send_request(rbav_pkg::ACT_PREPARE, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'd16, 32'd0);
      send_request(rbav_pkg::ACT_REVERT, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_PREPARE, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_PREPARE, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_FINISH, 17'd0, 32'd0);
      send_request(ActUnused6, 17'h1FFFF, 32'hFFFF_FFFF);
      send_request(ActUnused7, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_CLEAR, 17'd0, 32'd0);
   endtask

   task automatic test_config_extremes();
      wait_idle();
      write_csr(rbav_pkg::CSR_HEAP_BASE, 32'hFFFF_FFE0);
      // length above capacity saturates
      write_csr(rbav_pkg::CSR_HEAP_BYTES, 32'h0001_FFFF);
      send_request(rbav_pkg::ACT_ALLOC, 17'd32, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'd16, 32'd0);
      send_request(rbav_pkg::ACT_QUERY, 17'd0, 32'hFFFF_FFF0);
      send_request(rbav_pkg::ACT_QUERY, 17'd0, 32'h0000_0010);
      send_request(rbav_pkg::ACT_ALLOC, 17'h10000, 32'd0);
      wait_idle();
      // shrink below the upper pointer
      write_csr(rbav_pkg::CSR_HEAP_BYTES, 32'd32);
      send_request(rbav_pkg::ACT_ALLOC, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'd16, 32'd0);
      send_request(rbav_pkg::ACT_PREPARE, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_REVERT, 17'd0, 32'd0);
      wait_idle();
      // upper bits dropped, leaving a zero-length heap
      write_csr(rbav_pkg::CSR_HEAP_BYTES, 32'hFFFE_0000);
      write_csr(rbav_pkg::CSR_HEAP_BASE, 32'hFFFF_FFFF);
      send_request(rbav_pkg::ACT_CLEAR, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'd0, 32'd0);
      send_request(rbav_pkg::ACT_ALLOC, 17'd16, 32'd0);
      send_request(rbav_pkg::ACT_QUERY, 17'd0, 32'hFFFF_FFFF);
   endtask

   task automatic run_random_phase(int idle_pct, int stall_pct, logic [31:0] base,
                                   logic [31:0] bytes, int count);
      logic [2:0]  act;
      logic [16:0] size;
      logic [31:0] qaddr;
      int          pick;
      int          span;
      wait_idle();
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      write_csr(rbav_pkg::CSR_HEAP_BASE, base);
      write_csr(rbav_pkg::CSR_HEAP_BYTES, bytes);
      span = ((bytes & 32'h1FFFF) > 32'(HeapCap)) ? HeapCap : int'(bytes & 32'h1FFFF);
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 45)
            act = rbav_pkg::ACT_ALLOC;
         else if (pick < 70)
            act = rbav_pkg::ACT_QUERY;
         else if (pick < 79)
            act = rbav_pkg::ACT_PREPARE;
         else if (pick < 87)
            act = rbav_pkg::ACT_FINISH;
         else if (pick < 93)
            act = rbav_pkg::ACT_REVERT;
         else if (pick < 96)
            act = rbav_pkg::ACT_CLEAR;
         else
            act = $urandom_range(1) ? ActUnused6 : ActUnused7;
         pick = $urandom_range(9);
         // mostly small blocks so the ring fills over many words
         if (pick < 7)
            size = 17'($urandom_range(span / 6 + 1, 0));
         else if (pick < 9)
            size = 17'($urandom_range(span, 0));
         else
            size = 17'($urandom);
         if ($urandom_range(99) < 85)
            qaddr = base + $urandom_range(span + 32, 0);
         else
            qaddr = $urandom;
         send_request(act, size, qaddr);
      end
   endtask

   task automatic test_backpressure();
      int n;
      wait_idle();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_csr(rbav_pkg::CSR_HEAP_BYTES, 32'd256);
      hold_cycles = 300;
      for (n = 0; n < 40; n++) begin
         if (n % 3 == 2)
            send_request(rbav_pkg::ACT_QUERY, 17'd0, base_reg + $urandom_range(288, 0));
         else if (n % 11 == 10)
            send_request(rbav_pkg::ACT_PREPARE, 17'd0, 32'd0);
         else if (n % 13 == 12)
            send_request(rbav_pkg::ACT_FINISH, 17'd0, 32'd0);
         else
            send_request(rbav_pkg::ACT_ALLOC, 17'($urandom_range(48, 0)), 32'd0);
      end
      // sender pauses until every word has come back
      wait_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_extremes();
      run_random_phase(0, 0, $urandom, 32'd512, 160);
      run_random_phase(47, 0, $urandom, 32'd4096, 160);
      run_random_phase(0, 47, 32'hFFFF_F000, 32'd2048, 160);
      run_random_phase(35, 35, 32'd0, 32'd65536, 160);
      test_backpressure();
      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("** ring_bump_allocator_with_advance_unit: PASSED **");
      else
         $display("** ring_bump_allocator_with_advance_unit: FAILED **");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("%0t: timeout", $time);
      $display("** ring_bump_allocator_with_advance_unit: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/rbav_pkg.sv
rtl/core/rbav_req_stage.sv
rtl/core/rbav_alloc_core.sv
rtl/core/ring_bump_allocator_with_advance_unit.sv
bench/tb_ring_bump_allocator_with_advance_unit.sv
